### rtl/fbrf_pkg.sv
// ----------------------------------------------------------------------------
// fbrf_pkg
// shared types, constants and helpers of the framebuffer fill and read engine
// ----------------------------------------------------------------------------
package fbrf_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int BYTES_MAX  = 4;
    localparam int MEM_DEPTH  = MAX_WIDTH * MAX_HEIGHT * BYTES_MAX;
    localparam int ADDR_W     = $clog2(MEM_DEPTH);
    localparam int PIX_W      = $clog2(MAX_WIDTH * MAX_HEIGHT);

    localparam int DIM_W   = 9;
    localparam int COORD_W = 16;
    localparam int COLOR_W = 8;
    localparam int FMT_W   = 2;
    localparam int INDEX_W = 2;

    // register indexes
    localparam logic [INDEX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [INDEX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
    localparam logic [INDEX_W-1:0] REG_COLOR_FORMAT  = 2'd2;

    // color formats
    localparam logic [FMT_W-1:0] FMT_RGB565   = 2'd0;
    localparam logic [FMT_W-1:0] FMT_RGB888   = 2'd1;
    localparam logic [FMT_W-1:0] FMT_ARGB8888 = 2'd2;
    localparam logic [FMT_W-1:0] FMT_RGB565A8 = 2'd3;

    // commands
    localparam logic CMD_FILL = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [COLOR_W-1:0] ALPHA_OPAQUE = 8'hFF;

    localparam logic [DIM_W-1:0]   RESET_WIDTH  = DIM_W'(256);
    localparam logic [DIM_W-1:0]   RESET_HEIGHT = DIM_W'(256);

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [FMT_W-1:0] format;
    } cfg_t;

    typedef struct packed {
        logic                      command;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] rect_width;
        logic signed [COORD_W-1:0] rect_height;
        logic        [COLOR_W-1:0] fill_red;
        logic        [COLOR_W-1:0] fill_green;
        logic        [COLOR_W-1:0] fill_blue;
    } cmd_t;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic              en;
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [COLOR_W-1:0] wdata;
    } mem_req_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d, input int lim);
        logic [DIM_W-1:0] r;
        r = (int'(d) > lim) ? DIM_W'(lim) : d;
        return r;
    endfunction

    // multiply by bytes per pixel
    function automatic logic [ADDR_W-1:0] scale_bpp(input logic [FMT_W-1:0] fmt,
                                                    input logic [ADDR_W-1:0] v);
        logic [ADDR_W-1:0] r;
        case (fmt)
            FMT_RGB565:   r = v << 1;
            FMT_ARGB8888: r = v << 2;
            default:      r = (v << 1) + v;
        endcase
        return r;
    endfunction

endpackage

### rtl/fbrf_ram.sv
// ----------------------------------------------------------------------------
// fbrf_ram
// single port synchronous ram with registered read data
// ----------------------------------------------------------------------------
module fbrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end
            rdata <= mem[addr];
        end
    end

endmodule

### rtl/fbrf_engine.sv
// ----------------------------------------------------------------------------
// fbrf_engine
// command sequencer: clipping, address generation, byte writes and reads
// ----------------------------------------------------------------------------
module fbrf_engine (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  fbrf_pkg::cfg_t                       cfg,
    input  logic                                 cmd_valid,
    output logic                                 cmd_ready,
    input  fbrf_pkg::cmd_t                       cmd,
    output logic                                 res_valid,
    input  logic                                 res_ready,
    output fbrf_pkg::pixel_t                     res,
    output fbrf_pkg::mem_req_t                   mem,
    input  logic [fbrf_pkg::COLOR_W-1:0]         mem_rdata
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_SETUP = 8'b0000_0010,
        ST_MUL   = 8'b0000_0100,
        ST_ADDR  = 8'b0000_1000,
        ST_FILL  = 8'b0001_0000,
        ST_RD    = 8'b0010_0000,
        ST_RLAST = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

    localparam int DW = fbrf_pkg::DIM_W;
    localparam int AW = fbrf_pkg::ADDR_W;
    localparam int CW = fbrf_pkg::COLOR_W;
    localparam int SW = fbrf_pkg::COORD_W + 2;

    state_t                   state_reg, state_next;
    fbrf_pkg::cmd_t           cmd_reg;
    logic [DW-1:0]            x0_reg, x1_reg, y0_reg, y1_reg;
    logic [DW-1:0]            col_reg, row_cnt_reg;
    logic                     zero_reg;
    logic [fbrf_pkg::PIX_W-1:0] prod_reg;
    logic [AW-1:0]            pitch_reg, addr_reg, row_reg;
    logic [1:0]               byte_reg;
    logic                     rdv_reg;
    logic [1:0]               rdi_reg;
    logic [CW-1:0]            rb_reg [3];

    logic [DW-1:0]            act_w, act_h;
    logic signed [SW-1:0]     xs, ys, xe, ye, sws, shs, x0s, y0s, x1s, y1s;
    logic                     empty, oob;
    logic [2*DW-1:0]          mul_full;
    logic [2:0]               bpp, nrd;
    logic                     byte_last, col_last, row_last, rd_last;
    logic [15:0]              v565;
    logic [CW-1:0]            wbyte;
    logic [AW-1:0]            start_addr;

    assign act_w = fbrf_pkg::clamp_dim(cfg.width, fbrf_pkg::MAX_WIDTH);
    assign act_h = fbrf_pkg::clamp_dim(cfg.height, fbrf_pkg::MAX_HEIGHT);

    // clipping
    always_comb begin
        xs  = {{2{cmd_reg.pos_x[15]}}, cmd_reg.pos_x};
        ys  = {{2{cmd_reg.pos_y[15]}}, cmd_reg.pos_y};
        xe  = xs + {{2{cmd_reg.rect_width[15]}}, cmd_reg.rect_width};
        ye  = ys + {{2{cmd_reg.rect_height[15]}}, cmd_reg.rect_height};
        sws = {{(SW-DW){1'b0}}, act_w};
        shs = {{(SW-DW){1'b0}}, act_h};
        x0s = (xs > 0) ? xs : '0;
        y0s = (ys > 0) ? ys : '0;
        x1s = (xe < sws) ? xe : sws;
        y1s = (ye < shs) ? ye : shs;
        empty = (x1s <= x0s) || (y1s <= y0s);
        oob   = (xs < 0) || (xs >= sws) || (ys < 0) || (ys >= shs);
    end

    assign mul_full   = y0_reg * act_w;
    assign start_addr = fbrf_pkg::scale_bpp(cfg.format,
                            AW'(prod_reg) + AW'(x0_reg));

    always_comb begin
        case (cfg.format)
            fbrf_pkg::FMT_RGB565:   bpp = 3'd2;
            fbrf_pkg::FMT_ARGB8888: bpp = 3'd4;
            default:                bpp = 3'd3;
        endcase
        nrd = (cfg.format == fbrf_pkg::FMT_RGB565 ||
               cfg.format == fbrf_pkg::FMT_RGB565A8) ? 3'd2 : 3'd3;
    end

    assign byte_last = ({1'b0, byte_reg} == bpp - 3'd1);
    assign col_last  = (col_reg == x1_reg - DW'(1));
    assign row_last  = (row_cnt_reg == y1_reg - DW'(1));
    assign rd_last   = ({1'b0, byte_reg} == nrd - 3'd1);

    // packed byte to write
    always_comb begin
        v565 = {cmd_reg.fill_red[7:3], cmd_reg.fill_green[7:2], cmd_reg.fill_blue[7:3]};
        wbyte = '0;
        case (cfg.format)
            fbrf_pkg::FMT_RGB888: begin
                case (byte_reg)
                    2'd0:    wbyte = cmd_reg.fill_red;
                    2'd1:    wbyte = cmd_reg.fill_green;
                    default: wbyte = cmd_reg.fill_blue;
                endcase
            end
            fbrf_pkg::FMT_ARGB8888: begin
                case (byte_reg)
                    2'd0:    wbyte = cmd_reg.fill_blue;
                    2'd1:    wbyte = cmd_reg.fill_green;
                    2'd2:    wbyte = cmd_reg.fill_red;
                    default: wbyte = fbrf_pkg::ALPHA_OPAQUE;
                endcase
            end
            default: begin
                case (byte_reg)
                    2'd0:    wbyte = v565[7:0];
                    2'd1:    wbyte = v565[15:8];
                    default: wbyte = fbrf_pkg::ALPHA_OPAQUE;
                endcase
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (cmd_valid) state_next = ST_SETUP;
            ST_SETUP: begin
                if (cmd_reg.command == fbrf_pkg::CMD_READ) begin
                    state_next = oob ? ST_DONE : ST_MUL;
                end else begin
                    state_next = empty ? ST_DONE : ST_MUL;
                end
            end
            ST_MUL:   state_next = ST_ADDR;
            ST_ADDR:  state_next = (cmd_reg.command == fbrf_pkg::CMD_READ) ? ST_RD : ST_FILL;
            ST_FILL:  if (byte_last && col_last && row_last) state_next = ST_DONE;
            ST_RD:    if (rd_last) state_next = ST_RLAST;
            ST_RLAST: state_next = ST_DONE;
            ST_DONE:  if (res_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            rdv_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            rdv_reg   <= (state_reg == ST_RD);
        end
    end

    always_ff @(posedge aclk) begin
        rdi_reg <= byte_reg;
        if (rdv_reg) begin
            rb_reg[rdi_reg] <= mem_rdata;
        end
        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    cmd_reg <= cmd;
                end
            end
            ST_SETUP: begin
                x0_reg    <= x0s[DW-1:0];
                y0_reg    <= y0s[DW-1:0];
                x1_reg    <= x1s[DW-1:0];
                y1_reg    <= y1s[DW-1:0];
                zero_reg  <= (cmd_reg.command == fbrf_pkg::CMD_FILL) || oob;
                pitch_reg <= fbrf_pkg::scale_bpp(cfg.format, AW'(act_w));
            end
            ST_MUL: begin
                prod_reg <= mul_full[fbrf_pkg::PIX_W-1:0];
            end
            ST_ADDR: begin
                addr_reg    <= start_addr;
                row_reg     <= start_addr;
                col_reg     <= x0_reg;
                row_cnt_reg <= y0_reg;
                byte_reg    <= 2'd0;
            end
            ST_FILL: begin
                if (byte_last) begin
                    byte_reg <= 2'd0;
                    if (col_last) begin
                        col_reg     <= x0_reg;
                        row_cnt_reg <= row_cnt_reg + DW'(1);
                        row_reg     <= row_reg + pitch_reg;
                        addr_reg    <= row_reg + pitch_reg;
                    end else begin
                        col_reg  <= col_reg + DW'(1);
                        addr_reg <= addr_reg + AW'(1);
                    end
                end else begin
                    byte_reg <= byte_reg + 2'd1;
                    addr_reg <= addr_reg + AW'(1);
                end
            end
            ST_RD: begin
                byte_reg <= byte_reg + 2'd1;
                addr_reg <= addr_reg + AW'(1);
            end
            default: begin
            end
        endcase
    end

    // unpack read bytes
    always_comb begin
        res = '0;
        if (!zero_reg) begin
            case (cfg.format)
                fbrf_pkg::FMT_RGB888: begin
                    res.red   = rb_reg[0];
                    res.green = rb_reg[1];
                    res.blue  = rb_reg[2];
                end
                fbrf_pkg::FMT_ARGB8888: begin
                    res.red   = rb_reg[2];
                    res.green = rb_reg[1];
                    res.blue  = rb_reg[0];
                end
                default: begin
                    res.red   = {rb_reg[1][7:3], 3'b000};
                    res.green = {rb_reg[1][2:0], rb_reg[0][7:5], 2'b00};
                    res.blue  = {rb_reg[0][4:0], 3'b000};
                end
            endcase
        end
    end

    assign cmd_ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);

    always_comb begin
        mem.en    = (state_reg == ST_FILL) || (state_reg == ST_RD);
        mem.we    = (state_reg == ST_FILL);
        mem.addr  = addr_reg;
        mem.wdata = wbyte;
    end

endmodule

### rtl/framebuffer_rect_fill_pixel_read.sv
// ----------------------------------------------------------------------------
// framebuffer_rect_fill_pixel_read
// byte addressed framebuffer with clipped rectangle fill and pixel read
// ----------------------------------------------------------------------------
//  channel | ports          | direction | moves
//  --------+----------------+-----------+-------------------------------------
//  s_      | s_valid/ready  | in        | fill or read request
//  m_      | m_valid/ready  | out       | one result per request
//  cfg_    | cfg_valid/ready| in        | register index and write data
//
//  fill: setup, multiply and address steps, then one write per byte (clipped
//  area times bytes per pixel) through the single byte-wide frame memory port
//  read: the same steps, then two or three byte reads through that port and a
//  last read step; out of screen reads and empty fills go from setup to done
//  one request at a time; a new request is taken while a result waits in m_
//  frame memory is not cleared by reset; config regs reset synchronously
// ----------------------------------------------------------------------------
module framebuffer_rect_fill_pixel_read (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_command,
    input  logic signed [fbrf_pkg::COORD_W-1:0] s_pos_x,
    input  logic signed [fbrf_pkg::COORD_W-1:0] s_pos_y,
    input  logic signed [fbrf_pkg::COORD_W-1:0] s_rect_width,
    input  logic signed [fbrf_pkg::COORD_W-1:0] s_rect_height,
    input  logic [fbrf_pkg::COLOR_W-1:0]        s_fill_red,
    input  logic [fbrf_pkg::COLOR_W-1:0]        s_fill_green,
    input  logic [fbrf_pkg::COLOR_W-1:0]        s_fill_blue,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [fbrf_pkg::COLOR_W-1:0]        m_read_red,
    output logic [fbrf_pkg::COLOR_W-1:0]        m_read_green,
    output logic [fbrf_pkg::COLOR_W-1:0]        m_read_blue,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fbrf_pkg::INDEX_W-1:0]        cfg_index,
    input  logic [fbrf_pkg::DIM_W-1:0]          cfg_data
);

    fbrf_pkg::cfg_t      cfg_reg;
    fbrf_pkg::cmd_t      cmd;
    fbrf_pkg::pixel_t    res;
    fbrf_pkg::pixel_t    out_reg;
    fbrf_pkg::mem_req_t  mem;
    logic [fbrf_pkg::COLOR_W-1:0] mem_rdata;
    logic                res_valid, res_ready;
    logic                m_valid_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.width  <= fbrf_pkg::RESET_WIDTH;
            cfg_reg.height <= fbrf_pkg::RESET_HEIGHT;
            cfg_reg.format <= fbrf_pkg::FMT_RGB565;
        end else if (cfg_valid) begin
            case (cfg_index)
                fbrf_pkg::REG_SCREEN_WIDTH:  cfg_reg.width  <= cfg_data;
                fbrf_pkg::REG_SCREEN_HEIGHT: cfg_reg.height <= cfg_data;
                fbrf_pkg::REG_COLOR_FORMAT:  cfg_reg.format <= cfg_data[fbrf_pkg::FMT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        cmd.command     = s_command;
        cmd.pos_x       = s_pos_x;
        cmd.pos_y       = s_pos_y;
        cmd.rect_width  = s_rect_width;
        cmd.rect_height = s_rect_height;
        cmd.fill_red    = s_fill_red;
        cmd.fill_green  = s_fill_green;
        cmd.fill_blue   = s_fill_blue;
    end

    fbrf_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .cmd_valid (s_valid),
        .cmd_ready (s_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem       (mem),
        .mem_rdata (mem_rdata)
    );

    fbrf_ram #(
        .WIDTH (fbrf_pkg::COLOR_W),
        .DEPTH (fbrf_pkg::MEM_DEPTH)
    ) u_frame_mem (
        .aclk  (aclk),
        .en    (mem.en),
        .we    (mem.we),
        .addr  (mem.addr),
        .wdata (mem.wdata),
        .rdata (mem_rdata)
    );

    // output register
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_read_red   = out_reg.red;
    assign m_read_green = out_reg.green;
    assign m_read_blue  = out_reg.blue;

    a_busy_after_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("engine took a second request right after the first");

    a_result_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res_ready |=> m_valid)
        else $error("finished result did not reach the output register");

    a_write_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        mem.we |-> (mem.en && !s_ready))
        else $error("frame memory written while engine idle");

endmodule
